// ===== sv/iccm_pkg.sv =====
// shared types and constants for the iteration count colormap unit
package iccm_pkg;

  localparam int unsigned MaxNodes     = 16;
  localparam int unsigned PaletteDepth = 1024;
  localparam int unsigned MaxSteps     = 1024;

  localparam int unsigned ThrAddrW  = $clog2(MaxNodes);
  localparam int unsigned PalAddrW  = $clog2(PaletteDepth);
  localparam int unsigned NodeW     = 5;
  localparam int unsigned StepsW    = 11;
  localparam int unsigned CountW    = 16;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned DvdW      = 26;
  localparam int unsigned IdxW      = 15;
  localparam int unsigned DivCntW   = 5;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 40;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_THRESHOLD = 2'd1,
    KIND_PALETTE   = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_STEPS      = 1'b1
  } cfg_reg_e;

endpackage

// ===== sv/iccm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module iccm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/iteration_count_colormap_unit.sv =====
// top level of the iteration count colormap unit
//
//  channel  | signals                          | beat
//  ---------+----------------------------------+-------------------------------
//  pixel in | s_axis_tvalid/tready/tdata/tuser | pixel, threshold or palette write
//  color out| m_axis_tvalid/tready/tdata       | rgb and palette slot per pixel
//  config   | cfg_valid/ready/index/data       | register write, always ready
//
//  a pixel scans the threshold ram, one read per cycle, up to the matching slot;
//  one that falls above the first threshold and at or below a later one then
//  passes a 26-bit restoring divider, and every pixel ends with a palette ram
//  read and the output load.
//  reset restores node_count 2 and steps 16; both rams hold garbage until written.
//  a stalled output stops the pixel before its palette read.
module iteration_count_colormap_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // entry_index, count_value, red_in, green_in, blue_in, zero pad
  input  logic [iccm_pkg::InDataW-1:0]    s_axis_tdata_i,
  // kind
  input  logic [1:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // red, green, blue, palette_index, zero pad
  output logic [iccm_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [iccm_pkg::StepsW-1:0]     cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_DIV  = 6'b000100,
    S_CALC = 6'b001000,
    S_RD   = 6'b010000,
    S_WAIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [iccm_pkg::NodeW-1:0]    node_q;
  logic [iccm_pkg::StepsW-1:0]   steps_q;
  logic [iccm_pkg::CountW-1:0]   cnt_q, prev_q, den_q, rem_q;
  logic [iccm_pkg::ThrAddrW-1:0] k_q, seg_q;
  logic [iccm_pkg::DvdW-1:0]     dvd_q;
  logic [iccm_pkg::DivCntW-1:0]  div_cnt_q;
  logic [iccm_pkg::PalAddrW-1:0] idx_q;
  logic                          out_valid_q;
  logic [iccm_pkg::ColorW-1:0]   out_color_q;
  logic [iccm_pkg::PalAddrW-1:0] out_idx_q;

  logic                          in_beat, pixel_beat;
  iccm_pkg::kind_e               kind;
  logic [9:0]                    entry_index;
  logic [iccm_pkg::CountW-1:0]   count_value;
  logic [iccm_pkg::NodeW-1:0]    n_c;
  logic [iccm_pkg::StepsW-1:0]   steps_c;
  logic [iccm_pkg::IdxW-1:0]     last_c, sum_c, lim_c;
  logic [iccm_pkg::PalAddrW-1:0] last_idx, sum_idx;

  logic                          thr_we, thr_re;
  logic [iccm_pkg::ThrAddrW-1:0] thr_raddr;
  logic [iccm_pkg::CountW-1:0]   thr_rdata;
  logic                          pal_we, pal_re;
  logic [iccm_pkg::ColorW-1:0]   pal_rdata;

  logic                          hit, at_end, rd_free;
  logic [iccm_pkg::CountW:0]     rem_sh;
  logic                          rem_ge;

  assign kind        = iccm_pkg::kind_e'(s_axis_tuser_i);
  assign entry_index = s_axis_tdata_i[9:0];
  assign count_value = s_axis_tdata_i[25:10];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_beat         = s_axis_tvalid_i & s_axis_tready_o;
  assign pixel_beat      = in_beat && (kind == iccm_pkg::KIND_PIXEL);

  // register clamps
  always_comb begin
    priority if (node_q < iccm_pkg::NodeW'(2)) begin
      n_c = iccm_pkg::NodeW'(2);
    end else if (node_q > iccm_pkg::NodeW'(iccm_pkg::MaxNodes)) begin
      n_c = iccm_pkg::NodeW'(iccm_pkg::MaxNodes);
    end else begin
      n_c = node_q;
    end
    priority if (steps_q == '0) begin
      steps_c = iccm_pkg::StepsW'(1);
    end else if (steps_q > iccm_pkg::StepsW'(iccm_pkg::MaxSteps)) begin
      steps_c = iccm_pkg::StepsW'(iccm_pkg::MaxSteps);
    end else begin
      steps_c = steps_q;
    end
  end

  assign last_c = iccm_pkg::IdxW'((n_c - iccm_pkg::NodeW'(1)) * steps_c) - iccm_pkg::IdxW'(1);
  assign sum_c  = iccm_pkg::IdxW'(seg_q * steps_c) + iccm_pkg::IdxW'(dvd_q[iccm_pkg::StepsW-1:0]);
  assign lim_c  = (sum_c > last_c) ? last_c : sum_c;

  assign last_idx = (last_c > iccm_pkg::IdxW'(iccm_pkg::PaletteDepth - 1))
                  ? iccm_pkg::PalAddrW'(iccm_pkg::PaletteDepth - 1)
                  : last_c[iccm_pkg::PalAddrW-1:0];
  assign sum_idx  = (lim_c > iccm_pkg::IdxW'(iccm_pkg::PaletteDepth - 1))
                  ? iccm_pkg::PalAddrW'(iccm_pkg::PaletteDepth - 1)
                  : lim_c[iccm_pkg::PalAddrW-1:0];

  // threshold scan
  assign hit    = (cnt_q <= thr_rdata);
  assign at_end = ({1'b0, k_q} == (n_c - iccm_pkg::NodeW'(1)));

  assign thr_we    = in_beat && (kind == iccm_pkg::KIND_THRESHOLD)
                   && (entry_index[9:iccm_pkg::ThrAddrW] == '0);
  assign thr_re    = pixel_beat || ((state_q == S_SCAN) && !hit && !at_end);
  assign thr_raddr = (state_q == S_SCAN) ? (k_q + iccm_pkg::ThrAddrW'(1)) : '0;

  assign pal_we  = in_beat && (kind == iccm_pkg::KIND_PALETTE);
  assign rd_free = !out_valid_q || m_axis_tready_i;
  assign pal_re  = (state_q == S_RD) && rd_free;

  // restoring divider step
  assign rem_sh = {rem_q, dvd_q[iccm_pkg::DvdW-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  iccm_ram #(
    .Width (iccm_pkg::CountW),
    .Depth (iccm_pkg::MaxNodes)
  ) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (entry_index[iccm_pkg::ThrAddrW-1:0]),
    .wdata_i (count_value),
    .re_i    (thr_re),
    .raddr_i (thr_raddr),
    .rdata_o (thr_rdata)
  );

  iccm_ram #(
    .Width (iccm_pkg::ColorW),
    .Depth (iccm_pkg::PaletteDepth)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (entry_index[iccm_pkg::PalAddrW-1:0]),
    .wdata_i ({s_axis_tdata_i[33:26], s_axis_tdata_i[41:34], s_axis_tdata_i[49:42]}),
    .re_i    (pal_re),
    .raddr_i (idx_q),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pixel_beat) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit && (k_q != '0)) begin
          state_d = S_DIV;
        end else if (hit || at_end) begin
          state_d = S_RD;
        end
      end
      S_DIV: begin
        if (div_cnt_q == iccm_pkg::DivCntW'(iccm_pkg::DvdW - 1)) begin
          state_d = S_CALC;
        end
      end
      S_CALC: state_d = S_RD;
      S_RD: begin
        if (rd_free) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      node_q      <= iccm_pkg::NodeW'(2);
      steps_q     <= iccm_pkg::StepsW'(16);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (iccm_pkg::cfg_reg_e'(cfg_index_i))
          iccm_pkg::CFG_NODE_COUNT: node_q  <= cfg_data_i[iccm_pkg::NodeW-1:0];
          iccm_pkg::CFG_STEPS:      steps_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_WAIT) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pixel_beat) begin
      cnt_q <= count_value;
      k_q   <= '0;
    end
    if (state_q == S_SCAN) begin
      prev_q <= thr_rdata;
      if (!hit && !at_end) begin
        k_q <= k_q + iccm_pkg::ThrAddrW'(1);
      end
      if (hit && (k_q != '0)) begin
        seg_q     <= k_q - iccm_pkg::ThrAddrW'(1);
        den_q     <= thr_rdata - prev_q;
        dvd_q     <= iccm_pkg::DvdW'(steps_c * (cnt_q - prev_q));
        rem_q     <= '0;
        div_cnt_q <= '0;
      end else if (hit) begin
        idx_q <= '0;
      end else if (at_end) begin
        idx_q <= last_idx;
      end
    end
    if (state_q == S_DIV) begin
      rem_q     <= rem_ge ? iccm_pkg::CountW'(rem_sh - {1'b0, den_q})
                          : rem_sh[iccm_pkg::CountW-1:0];
      dvd_q     <= {dvd_q[iccm_pkg::DvdW-2:0], rem_ge};
      div_cnt_q <= div_cnt_q + iccm_pkg::DivCntW'(1);
    end
    if (state_q == S_CALC) begin
      idx_q <= sum_idx;
    end
    if (state_q == S_WAIT) begin
      out_color_q <= pal_rdata;
      out_idx_q   <= idx_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_idx_q, out_color_q[7:0], out_color_q[15:8],
                            out_color_q[23:16]};

  a_pixel_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_beat |=> (state_q == S_SCAN))
    else $error("pixel beat did not start a threshold scan");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (kind != iccm_pkg::KIND_PIXEL)) |=> (state_q == S_IDLE))
    else $error("write beat left the idle state");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> !out_valid_q)
    else $error("palette data arrived while output still occupied");

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the iteration count colormap unit: prediction, stream driving and checking
module tb_top;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] slot;
  } color_beat_t;

  class color_scoreboard;
    logic [iccm_pkg::CountW-1:0] thr_tbl [iccm_pkg::MaxNodes];
    logic [iccm_pkg::ColorW-1:0] pal_tbl [iccm_pkg::PaletteDepth];
    logic [iccm_pkg::NodeW-1:0]  node_reg;
    logic [iccm_pkg::StepsW-1:0] steps_reg;
    color_beat_t                 color_q [$];
    int unsigned                 bad_beats;
    int unsigned                 seen_beats;

    function new();
      node_reg   = 5'd2;
      steps_reg  = 11'd16;
      bad_beats  = 0;
      seen_beats = 0;
    endfunction

    function void write_register(iccm_pkg::cfg_reg_e idx,
                                 logic [iccm_pkg::StepsW-1:0] val);
      if (idx == iccm_pkg::CFG_NODE_COUNT) node_reg = val[iccm_pkg::NodeW-1:0];
      else steps_reg = val;
    endfunction

    function void note_input(iccm_pkg::kind_e kind, logic [iccm_pkg::InDataW-1:0] data);
      int unsigned slot, cnt, n, s, top, idx, k, lo, hi;
      logic [iccm_pkg::ColorW-1:0] rgb;
      color_beat_t want;
      slot = 32'(data[9:0]);
      cnt  = 32'(data[25:10]);
      case (kind)
        iccm_pkg::KIND_THRESHOLD: begin
          if (slot < iccm_pkg::MaxNodes) thr_tbl[slot] = data[25:10];
        end
        iccm_pkg::KIND_PALETTE: begin
          pal_tbl[slot] = {data[33:26], data[41:34], data[49:42]};
        end
        iccm_pkg::KIND_PIXEL: begin
          n = 32'(node_reg);
          if (n < 2) n = 2;
          if (n > iccm_pkg::MaxNodes) n = iccm_pkg::MaxNodes;
          s = 32'(steps_reg);
          if (s < 1) s = 1;
          if (s > iccm_pkg::MaxSteps) s = iccm_pkg::MaxSteps;
          top = (n - 1) * s - 1;
          idx = top;
          k = 0;
          while (k < n && cnt > thr_tbl[k]) k++;
          if (k < n) begin
            if (k == 0) begin
              idx = 0;
            end else begin
              lo  = 32'(thr_tbl[k-1]);
              hi  = 32'(thr_tbl[k]);
              idx = (k - 1) * s;
              if (cnt > lo && hi != lo) idx += (s * (cnt - lo)) / (hi - lo);
            end
          end
          if (idx > top) idx = top;
          if (idx > iccm_pkg::PaletteDepth - 1) idx = iccm_pkg::PaletteDepth - 1;
          rgb        = pal_tbl[idx];
          want.red   = rgb[23:16];
          want.green = rgb[15:8];
          want.blue  = rgb[7:0];
          want.slot  = idx[9:0];
          color_q.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic [iccm_pkg::OutDataW-1:0] data);
      color_beat_t want;
      seen_beats++;
      if (color_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("color beat %0d: nothing expected, got r=%h g=%h b=%h slot=%0d",
                   seen_beats, data[7:0], data[15:8], data[23:16], data[33:24]);
        return;
      end
      want = color_q.pop_front();
      if (data[7:0] !== want.red || data[15:8] !== want.green ||
          data[23:16] !== want.blue || data[33:24] !== want.slot) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("color beat %0d: expected r=%h g=%h b=%h slot=%0d, got r=%h g=%h b=%h slot=%0d",
                   seen_beats, want.red, want.green, want.blue, want.slot,
                   data[7:0], data[15:8], data[23:16], data[33:24]);
      end
    endfunction

    function int unsigned waiting();
      return color_q.size();
    endfunction

    function bit failed();
      return bad_beats != 0 || color_q.size() != 0;
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_valid = 1'b0;
  logic [iccm_pkg::InDataW-1:0]  s_data = '0;
  logic [1:0]                    s_user = iccm_pkg::KIND_PIXEL;
  logic                          m_ready = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_index = iccm_pkg::CFG_NODE_COUNT;
  logic [iccm_pkg::StepsW-1:0]   cfg_data = '0;
  logic                          s_axis_tready_o;
  logic                          m_axis_tvalid_o;
  logic [iccm_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          cfg_ready_o;

  logic [iccm_pkg::CountW-1:0]   thr_now [iccm_pkg::MaxNodes];
  bit                            src_gaps = 1'b0;
  bit                            sink_stalls = 1'b0;
  int unsigned                   stall_hold = 0;
  int unsigned                   cycle_count = 0;

  color_scoreboard sb = new();

  iteration_count_colormap_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) sb.check_output(m_axis_tdata_o);
  end

  // output back-pressure in random bursts
  always @(negedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
      m_ready <= 1'b0;
      stall_hold = $urandom_range(0, 2);
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic send_beat(iccm_pkg::kind_e kind, logic [9:0] slot,
                           logic [iccm_pkg::CountW-1:0] cnt,
                           logic [iccm_pkg::ColorW-1:0] rgb);
    int unsigned gap;
    logic [iccm_pkg::InDataW-1:0] beat;
    beat = {6'b0, rgb[7:0], rgb[15:8], rgb[23:16], cnt, slot};
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= beat;
    s_user  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(kind, beat);
    if (kind == iccm_pkg::KIND_THRESHOLD && slot < iccm_pkg::MaxNodes)
      thr_now[slot[iccm_pkg::ThrAddrW-1:0]] = cnt;
  endtask

  task automatic load_register(iccm_pkg::cfg_reg_e idx, logic [iccm_pkg::StepsW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, val);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_thresholds(int unsigned spread, bit scrambled);
    int unsigned v;
    v = $urandom_range(0, spread);
    for (int i = 0; i < iccm_pkg::MaxNodes; i++) begin
      send_beat(iccm_pkg::KIND_THRESHOLD, 10'(i),
                scrambled ? iccm_pkg::CountW'($urandom()) : iccm_pkg::CountW'(v),
                iccm_pkg::ColorW'($urandom()));
      v = v + $urandom_range(0, spread);
      if (v > 65535) v = 65535;
    end
  endtask

  // counts aimed at the thresholds and the segments between them
  function automatic logic [iccm_pkg::CountW-1:0] aimed_count();
    int unsigned k;
    k = $urandom_range(0, iccm_pkg::MaxNodes - 1);
    case ($urandom_range(0, 6))
      0: return thr_now[k];
      1: return (thr_now[k] == 16'hFFFF) ? thr_now[k] : thr_now[k] + 16'd1;
      2: return (thr_now[k] == 16'h0000) ? thr_now[k] : thr_now[k] - 16'd1;
      3, 4: return (k == 0)
               ? iccm_pkg::CountW'($urandom_range(0, thr_now[0]))
               : iccm_pkg::CountW'($urandom_range(thr_now[k-1], thr_now[k]));
      5: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return iccm_pkg::CountW'($urandom());
    endcase
  endfunction

  task automatic run_phase(logic [iccm_pkg::StepsW-1:0] nodes_val,
                           logic [iccm_pkg::StepsW-1:0] steps_val,
                           int unsigned items, bit idle);
    int unsigned pick;
    src_gaps    = idle;
    sink_stalls = idle;
    load_register(iccm_pkg::CFG_NODE_COUNT, nodes_val);
    load_register(iccm_pkg::CFG_STEPS, steps_val);
    case ($urandom_range(0, 4))
      0: load_thresholds(1, 1'b0);
      1: load_thresholds(64, 1'b0);
      2: load_thresholds(4095, 1'b0);
      3: load_thresholds(0, 1'b1);
      default: ;
    endcase
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_beat(iccm_pkg::KIND_PIXEL, 10'($urandom()), aimed_count(),
                  iccm_pkg::ColorW'($urandom()));
      else if (pick < 80)
        send_beat(iccm_pkg::KIND_PALETTE, 10'($urandom()), iccm_pkg::CountW'($urandom()),
                  iccm_pkg::ColorW'($urandom()));
      else if (pick < 88)
        send_beat(iccm_pkg::KIND_THRESHOLD,
                  10'($urandom_range(0, 1) ? $urandom_range(0, iccm_pkg::MaxNodes - 1)
                                           : $urandom()),
                  iccm_pkg::CountW'($urandom()), iccm_pkg::ColorW'($urandom()));
      else if (pick < 93)
        send_beat(iccm_pkg::KIND_UNUSED, 10'($urandom()), iccm_pkg::CountW'($urandom()),
                  iccm_pkg::ColorW'($urandom()));
      else
        send_beat(iccm_pkg::KIND_PIXEL, 10'($urandom()), iccm_pkg::CountW'($urandom()),
                  iccm_pkg::ColorW'($urandom()));
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill both tables so no pixel reads an unwritten entry
    send_beat(iccm_pkg::KIND_THRESHOLD, 10'd0, 16'd100, iccm_pkg::ColorW'($urandom()));
    send_beat(iccm_pkg::KIND_THRESHOLD, 10'd1, 16'd200, iccm_pkg::ColorW'($urandom()));
    send_beat(iccm_pkg::KIND_THRESHOLD, 10'd2, 16'd1000, iccm_pkg::ColorW'($urandom()));
    send_beat(iccm_pkg::KIND_THRESHOLD, 10'd3, 16'd60000, iccm_pkg::ColorW'($urandom()));
    for (int i = 4; i < iccm_pkg::MaxNodes; i++)
      send_beat(iccm_pkg::KIND_THRESHOLD, 10'(i), iccm_pkg::CountW'(61000 + i * 100),
                iccm_pkg::ColorW'($urandom()));
    for (int i = 0; i < iccm_pkg::PaletteDepth; i++)
      send_beat(iccm_pkg::KIND_PALETTE, 10'(i), iccm_pkg::CountW'($urandom()),
                iccm_pkg::ColorW'($urandom()));
    drain();

    load_register(iccm_pkg::CFG_NODE_COUNT, 11'd4);
    load_register(iccm_pkg::CFG_STEPS, 11'd10);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd0, 24'h0);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd100, 24'h0);
    send_beat(iccm_pkg::KIND_PIXEL, 10'h3FF, 16'd101, 24'hFFFFFF);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd200, 24'h0);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd999, 24'h0);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd60000, 24'h0);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'hFFFF, 24'h0);
    send_beat(iccm_pkg::KIND_UNUSED, 10'h3FF, 16'hFFFF, 24'hFFFFFF);
    // out of range threshold slots are dropped
    send_beat(iccm_pkg::KIND_THRESHOLD, 10'd16, 16'd0, 24'h0);
    send_beat(iccm_pkg::KIND_THRESHOLD, 10'h3FF, 16'd0, 24'h0);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd50, 24'h0);
    // equal neighbors
    send_beat(iccm_pkg::KIND_THRESHOLD, 10'd1, 16'd100, 24'h0);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd100, 24'h0);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd101, 24'h0);
    // out of order threshold
    send_beat(iccm_pkg::KIND_THRESHOLD, 10'd2, 16'd50, 24'h0);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd150, 24'h0);
    send_beat(iccm_pkg::KIND_PALETTE, 10'd0, 16'd0, 24'hFF00FF);
    send_beat(iccm_pkg::KIND_PIXEL, 10'd0, 16'd0, 24'h0);
    drain();

    run_phase(11'd16, 11'd1024, 20, 1'b1);
    run_phase(11'd0, 11'd0, 15, 1'b0);
    run_phase(11'd1, 11'h7FF, 15, 1'b1);
    run_phase(11'h7FF, 11'd1, 15, 1'b1);
    run_phase(11'd2, 11'd1, 15, 1'b1);
    run_phase(11'd8, 11'd100, 20, 1'b1);
    repeat (5) run_phase(iccm_pkg::StepsW'($urandom_range(0, 2047)),
                         iccm_pkg::StepsW'($urandom_range(0, 2047)), 15,
                         $urandom_range(0, 3) != 0);
    run_phase(11'd16, 11'd64, 25, 1'b0);

    if (sb.failed()) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      $display("SCOREBOARD CLEAN");
    end
    $finish;
  end

endmodule

// ===== iteration_count_colormap_unit.f =====
sv/iccm_pkg.sv
sv/iccm_ram.sv
sv/iteration_count_colormap_unit.sv
tb/sv/tb_top.sv
